// File: sv/ip_fragment_range_tracker_top_macros.svh
// Assertion macros for the IP fragment range tracker.
// Used by ip_fragment_range_tracker_top; expects clk and rst_n in scope.
`ifndef IP_FRAGMENT_RANGE_TRACKER_TOP_MACROS_SVH
`define IP_FRAGMENT_RANGE_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IFRT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IFRT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ifrt_pkg.sv
// Shared types and constants of the IP fragment range tracker.
// No dependencies; imported by ifrt_ram and ip_fragment_range_tracker_top.
package ifrt_pkg;

    localparam int LEN_W          = 17;  // byte position / range length
    localparam int OFF_W          = 13;  // offset field in 8-byte units
    localparam int PLEN_W         = 16;  // payload length field
    localparam int OFFB_W         = 16;  // offset in bytes
    localparam int CNT_OUT_W      = 5;   // range_count result field
    localparam int ENTRY_W        = 2 * LEN_W;
    localparam int FRAG_SLOTS_DEF = 16;

    typedef enum logic [1:0] {
        ST_MERGED   = 2'd0,
        ST_INSERTED = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_CLEARED  = 2'd3
    } status_t;

    typedef struct packed {
        logic              kind;
        logic [OFF_W-1:0]  offset_units;
        logic [PLEN_W-1:0] payload_len;
        logic              more_frags;
    } frag_t;

    typedef struct packed {
        status_t              status;
        logic                 complete;
        logic [LEN_W-1:0]     end_byte;
        logic [CNT_OUT_W-1:0] range_count;
    } res_t;

endpackage

// File: sv/ifrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on ifrt_pkg for default sizes only.
module ifrt_ram
    import ifrt_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = FRAG_SLOTS_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/ip_fragment_range_tracker_top.sv
// Top level of the IP fragment range tracker: sequencer, range table RAM, result register.
// Depends on ifrt_pkg, ifrt_ram and ip_fragment_range_tracker_top_macros.svh.
//
// Use: one datagram's byte ranges are tracked in a table sorted by start byte.
// Input channel frag (frag_valid / frag_stall): kind 1 clears the tracker, kind 0
// adds the fragment at offset_units*8 with payload_len bytes. Output channel res
// (res_valid / res_stall) returns one transaction per input: status, complete,
// end_byte (largest end byte seen) and range_count.
// Timing: a clear goes straight to the done state. A fragment walks the table one
// entry per cycle; an insert then shifts the later entries one per cycle. A place
// or merge step (none on overflow) and a finish step follow; once the last fragment
// has been seen, the completion check then walks the stored entries, up to FRAG_SLOTS.
// The result is loaded from the done state, and frag_stall drops as it is loaded;
// no new fragment is accepted until then. The pace is set by the single read port of
// the range table RAM, which one adder and comparator set service entry by entry.
// frag_stall is high while an item is in work.
// A finished result sits in the output register; the next item is accepted while
// it waits. If res_stall holds the register full when the next result is ready,
// the sequencer waits. Reset empties the table, clears the end and last-fragment
// marks and drops any pending result.
module ip_fragment_range_tracker_top
    import ifrt_pkg::*;
#(
    parameter int FRAG_SLOTS = FRAG_SLOTS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  frag_valid,
    output logic  frag_stall,
    input  frag_t frag,
    output logic  res_valid,
    input  logic  res_stall,
    output res_t  res
);

    localparam int AW = $clog2(FRAG_SLOTS);
    localparam int IW = $clog2(FRAG_SLOTS + 1);
    localparam int CW = LEN_W + AW;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_WALK   = 8'b0000_0010,
        S_SHIFT  = 8'b0000_0100,
        S_PLACE  = 8'b0000_1000,
        S_MERGE  = 8'b0001_0000,
        S_FINISH = 8'b0010_0000,
        S_CHECK  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     j_reg, j_next;
    logic [IW-1:0]     cnt_reg, cnt_next;
    logic [LEN_W-1:0]  max_end_reg, max_end_next;
    logic              last_reg, last_next;
    logic [OFFB_W-1:0] off_reg, off_next;
    logic [PLEN_W-1:0] len_reg, len_next;
    logic              more_reg, more_next;
    logic [LEN_W-1:0]  end_reg, end_next;
    status_t           status_reg, status_next;
    logic              complete_reg, complete_next;
    logic [LEN_W-1:0]  ent_len_reg, ent_len_next;
    logic [LEN_W-1:0]  wr_start_reg, wr_start_next;
    logic [CW-1:0]     cur_reg, cur_next;
    res_t              res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    logic                we;
    logic [AW-1:0]       waddr;
    logic [ENTRY_W-1:0]  wdata;
    logic [AW-1:0]       raddr;
    logic [ENTRY_W-1:0]  rdata;
    logic [LEN_W-1:0]    rd_s;
    logic [LEN_W-1:0]    rd_l;

    logic [CW-1:0]       add_a, add_b, sum;
    logic [OFFB_W-1:0]   off_in;
    logic [IW-1:0]       idx_inc;
    logic [IW-1:0]       cnt_m1;
    logic                full;
    logic                accept;

    ifrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FRAG_SLOTS)
    ) u_ranges (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_s    = rdata[ENTRY_W-1:LEN_W];
    assign rd_l    = rdata[LEN_W-1:0];
    assign off_in  = {frag.offset_units, 3'b000};
    assign idx_inc = idx_reg + IW'(1);
    assign cnt_m1  = cnt_reg - IW'(1);
    assign full    = (cnt_reg == IW'(FRAG_SLOTS));

    assign frag_stall = (state_reg != S_IDLE);
    assign accept     = frag_valid && (state_reg == S_IDLE);
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    // Shared adder: operands picked by the sequencer state.
    always_comb
    begin
        add_a = '0;
        add_b = '0;
        case (state_reg)
            S_IDLE:
            begin
                add_a = CW'(off_in);
                add_b = CW'(frag.payload_len);
            end
            S_WALK:
            begin
                add_a = CW'(rd_s);
                add_b = CW'(rd_l);
            end
            S_MERGE:
            begin
                add_a = CW'(ent_len_reg);
                add_b = CW'(len_reg);
            end
            S_CHECK:
            begin
                add_a = cur_reg;
                add_b = CW'(rd_l);
            end
            default:
            begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end

    assign sum = add_a + add_b;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        max_end_next   = max_end_reg;
        last_next      = last_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        more_next      = more_reg;
        end_next       = end_reg;
        status_next    = status_reg;
        complete_next  = complete_reg;
        ent_len_next   = ent_len_reg;
        wr_start_next  = wr_start_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;
        raddr          = '0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    off_next  = off_in;
                    len_next  = frag.payload_len;
                    more_next = frag.more_frags;
                    end_next  = sum[LEN_W-1:0];
                    idx_next  = '0;
                    if (frag.kind)
                    begin
                        cnt_next      = '0;
                        max_end_next  = '0;
                        last_next     = 1'b0;
                        status_next   = ST_CLEARED;
                        complete_next = 1'b0;
                        state_next    = S_DONE;
                    end
                    else if (cnt_reg == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        raddr      = '0;
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (sum == CW'(off_reg))
                begin
                    // entry ends at the new start: extend it upward
                    ent_len_next  = rd_l;
                    wr_start_next = rd_s;
                    state_next    = S_MERGE;
                end
                else if (rd_s < {1'b0, off_reg})
                begin
                    if (idx_inc == cnt_reg)
                    begin
                        if (full)
                        begin
                            status_next = ST_OVERFLOW;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            idx_next   = idx_inc;
                            state_next = S_PLACE;
                        end
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        raddr    = idx_inc[AW-1:0];
                    end
                end
                else if (rd_s == end_reg)
                begin
                    // entry starts at the new end: extend it downward
                    ent_len_next  = rd_l;
                    wr_start_next = {1'b0, off_reg};
                    state_next    = S_MERGE;
                end
                else if (full)
                begin
                    status_next = ST_OVERFLOW;
                    state_next  = S_FINISH;
                end
                else
                begin
                    j_next     = cnt_m1[AW-1:0];
                    raddr      = cnt_m1[AW-1:0];
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // move entry j up one slot, last entry first
                we    = 1'b1;
                waddr = j_reg + AW'(1);
                wdata = rdata;
                if (j_reg == idx_reg[AW-1:0])
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    j_next = j_reg - AW'(1);
                    raddr  = j_reg - AW'(1);
                end
            end
            S_PLACE:
            begin
                we          = 1'b1;
                waddr       = idx_reg[AW-1:0];
                wdata       = {LEN_W'(off_reg), LEN_W'(len_reg)};
                status_next = ST_INSERTED;
                state_next  = S_FINISH;
            end
            S_MERGE:
            begin
                we          = 1'b1;
                waddr       = idx_reg[AW-1:0];
                wdata       = {wr_start_reg, sum[LEN_W-1:0]};
                status_next = ST_MERGED;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (status_reg != ST_OVERFLOW)
                begin
                    if (end_reg > max_end_reg)
                    begin
                        max_end_next = end_reg;
                    end
                    if (!more_reg)
                    begin
                        last_next = 1'b1;
                    end
                    if (status_reg == ST_INSERTED)
                    begin
                        cnt_next = cnt_reg + IW'(1);
                    end
                end
                if (!last_next || (cnt_next == '0))
                begin
                    complete_next = 1'b0;
                    state_next    = S_DONE;
                end
                else
                begin
                    idx_next   = '0;
                    cur_next   = '0;
                    raddr      = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (CW'(rd_s) != cur_reg)
                begin
                    complete_next = 1'b0;
                    state_next    = S_DONE;
                end
                else if (sum == CW'(max_end_reg))
                begin
                    complete_next = 1'b1;
                    state_next    = S_DONE;
                end
                else if (idx_inc == cnt_reg)
                begin
                    complete_next = 1'b0;
                    state_next    = S_DONE;
                end
                else
                begin
                    idx_next = idx_inc;
                    cur_next = sum;
                    raddr    = idx_inc[AW-1:0];
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!res_valid_reg || !res_stall)
                begin
                    res_next.status      = status_reg;
                    res_next.complete    = complete_reg;
                    res_next.end_byte    = max_end_reg;
                    res_next.range_count = CNT_OUT_W'(cnt_reg);
                    res_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            max_end_reg   <= '0;
            last_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            max_end_reg   <= max_end_next;
            last_reg      <= last_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        j_reg        <= j_next;
        off_reg      <= off_next;
        len_reg      <= len_next;
        more_reg     <= more_next;
        end_reg      <= end_next;
        status_reg   <= status_next;
        complete_reg <= complete_next;
        ent_len_reg  <= ent_len_next;
        wr_start_reg <= wr_start_next;
        cur_reg      <= cur_next;
        res_reg      <= res_next;
    end

`include "ip_fragment_range_tracker_top_macros.svh"

    `IFRT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= IW'(FRAG_SLOTS), "range count over size")
    `IFRT_ASSERT_IMP(a_shift_room, state_reg == S_SHIFT, !full, "shift with full table")
    `IFRT_ASSERT_IMP(a_check_ready, state_reg == S_CHECK, last_reg && (cnt_reg != '0), "early check")
    `IFRT_ASSERT_NXT(a_clear, accept && frag.kind, (cnt_reg == '0) && !last_reg, "clear left state")

endmodule
